// File: design/hll_riemann_flux_top_assert.svh
// Assertion macros for the HLL flux block; clock i_clk, active-low reset i_rst_n.
`ifndef HLL_RIEMANN_FLUX_TOP_ASSERT_SVH
`define HLL_RIEMANN_FLUX_TOP_ASSERT_SVH

// Same-cycle implication
`define HRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hrf_pkg.sv
`default_nettype none

package hrf_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int GAMMA_W = 18;
    localparam int MEM_AW  = 7;
    localparam int PC_W    = 7;

    localparam logic [GAMMA_W-1:0] GAMMA_RST = 18'd91750;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_word HALF     = t_word'(64'd1 << (FRAC_W-1));
    localparam t_word ONE      = t_word'(64'd1 << FRAC_W);

    // One interface job: stored left state, right state, normal axis
    typedef struct packed {
        logic         present;
        logic         axis;
        t_word [8:0]  lw;
        t_word [8:0]  rw;
    } t_job;

    localparam logic [1:0] REGION_LEFT  = 2'd0;
    localparam logic [1:0] REGION_RIGHT = 2'd1;
    localparam logic [1:0] REGION_BLEND = 2'd2;

    // Micro-op codes of the back end sequencer
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MIN    = 4'd2;
    localparam logic [3:0] OP_MAX    = 4'd3;
    localparam logic [3:0] OP_MUL    = 4'd4;
    localparam logic [3:0] OP_DIV    = 4'd5;
    localparam logic [3:0] OP_SQRT   = 4'd6;
    localparam logic [3:0] OP_SQRTF  = 4'd7;
    localparam logic [3:0] OP_POS2   = 4'd8;
    localparam logic [3:0] OP_DECIDE = 4'd9;
    localparam logic [3:0] OP_OUTS   = 4'd10;
    localparam logic [3:0] OP_OUTW   = 4'd11;
    localparam logic [3:0] OP_FIN    = 4'd12;

    localparam logic [PC_W-1:0] PC_SEL   = 7'd46;
    localparam logic [PC_W-1:0] PC_FIN   = 7'd50;
    localparam logic [PC_W-1:0] PC_BLEND = 7'd51;

    typedef struct packed {
        logic [3:0]        op;
        logic [MEM_AW-1:0] dst;
        logic [MEM_AW-1:0] src_a;
        logic [MEM_AW-1:0] src_b;
    } t_uop;

    function automatic t_uop mk(input logic [3:0] op, input logic [MEM_AW-1:0] d,
                                input logic [MEM_AW-1:0] a, input logic [MEM_AW-1:0] b);
        t_uop u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        return u;
    endfunction

    // Scratch map: 0..8 left, 9..17 right, 18 gamma, 19 half, 20 one,
    // 21/22 left/right normal momentum, 24 and up temporaries.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            7'd0:  u = mk(OP_DIV,   7'd24, 7'd21, 7'd0);
            7'd1:  u = mk(OP_DIV,   7'd25, 7'd22, 7'd9);
            7'd2:  u = mk(OP_MUL,   7'd26, 7'd18, 7'd4);
            7'd3:  u = mk(OP_DIV,   7'd27, 7'd26, 7'd0);
            7'd4:  u = mk(OP_SQRT,  7'd28, 7'd27, 7'd0);
            7'd5:  u = mk(OP_MUL,   7'd29, 7'd18, 7'd13);
            7'd6:  u = mk(OP_DIV,   7'd30, 7'd29, 7'd9);
            7'd7:  u = mk(OP_SQRT,  7'd31, 7'd30, 7'd0);
            7'd8:  u = mk(OP_ADD,   7'd32, 7'd28, 7'd31);
            7'd9:  u = mk(OP_MUL,   7'd33, 7'd19, 7'd32);
            7'd10: u = mk(OP_ADD,   7'd34, 7'd0,  7'd9);
            7'd11: u = mk(OP_MUL,   7'd35, 7'd19, 7'd34);
            7'd12: u = mk(OP_MUL,   7'd36, 7'd35, 7'd33);
            7'd13: u = mk(OP_ADD,   7'd37, 7'd4,  7'd13);
            7'd14: u = mk(OP_MUL,   7'd38, 7'd19, 7'd37);
            7'd15: u = mk(OP_SUB,   7'd39, 7'd25, 7'd24);
            7'd16: u = mk(OP_MUL,   7'd40, 7'd19, 7'd39);
            7'd17: u = mk(OP_MUL,   7'd41, 7'd40, 7'd36);
            7'd18: u = mk(OP_SUB,   7'd42, 7'd38, 7'd41);
            7'd19: u = mk(OP_ADD,   7'd43, 7'd25, 7'd24);
            7'd20: u = mk(OP_MUL,   7'd44, 7'd19, 7'd43);
            7'd21: u = mk(OP_SUB,   7'd45, 7'd13, 7'd4);
            7'd22: u = mk(OP_MUL,   7'd46, 7'd19, 7'd45);
            7'd23: u = mk(OP_DIV,   7'd47, 7'd46, 7'd36);
            7'd24: u = mk(OP_SUB,   7'd48, 7'd44, 7'd47);
            7'd25: u = mk(OP_DIV,   7'd49, 7'd35, 7'd33);
            7'd26: u = mk(OP_SUB,   7'd50, 7'd24, 7'd48);
            7'd27: u = mk(OP_MUL,   7'd51, 7'd50, 7'd49);
            7'd28: u = mk(OP_ADD,   7'd52, 7'd0,  7'd51);
            7'd29: u = mk(OP_SUB,   7'd53, 7'd25, 7'd48);
            7'd30: u = mk(OP_MUL,   7'd54, 7'd53, 7'd49);
            7'd31: u = mk(OP_SUB,   7'd55, 7'd9,  7'd54);
            7'd32: u = mk(OP_MUL,   7'd56, 7'd18, 7'd42);
            7'd33: u = mk(OP_DIV,   7'd57, 7'd56, 7'd52);
            7'd34: u = mk(OP_POS2,  7'd0,  7'd42, 7'd52);
            7'd35: u = mk(OP_SQRTF, 7'd59, 7'd57, 7'd0);
            7'd36: u = mk(OP_DIV,   7'd60, 7'd56, 7'd55);
            7'd37: u = mk(OP_POS2,  7'd0,  7'd42, 7'd55);
            7'd38: u = mk(OP_SQRTF, 7'd61, 7'd60, 7'd0);
            7'd39: u = mk(OP_SUB,   7'd62, 7'd24, 7'd28);
            7'd40: u = mk(OP_SUB,   7'd63, 7'd48, 7'd59);
            7'd41: u = mk(OP_MIN,   7'd64, 7'd62, 7'd63);
            7'd42: u = mk(OP_ADD,   7'd65, 7'd25, 7'd31);
            7'd43: u = mk(OP_ADD,   7'd66, 7'd48, 7'd61);
            7'd44: u = mk(OP_MAX,   7'd67, 7'd65, 7'd66);
            7'd45: u = mk(OP_DECIDE, 7'd0, 7'd64, 7'd67);
            7'd46: u = mk(OP_OUTS,  7'd0,  7'd5,  7'd14);
            7'd47: u = mk(OP_OUTS,  7'd1,  7'd6,  7'd15);
            7'd48: u = mk(OP_OUTS,  7'd2,  7'd7,  7'd16);
            7'd49: u = mk(OP_OUTS,  7'd3,  7'd8,  7'd17);
            7'd50: u = mk(OP_FIN,   7'd0,  7'd0,  7'd0);
            7'd51: u = mk(OP_MUL,   7'd68, 7'd64, 7'd67);
            7'd52: u = mk(OP_SUB,   7'd69, 7'd67, 7'd64);
            7'd53: u = mk(OP_DIV,   7'd70, 7'd20, 7'd69);
            7'd54: u = mk(OP_MUL,   7'd71, 7'd67, 7'd5);
            7'd55: u = mk(OP_MUL,   7'd72, 7'd64, 7'd14);
            7'd56: u = mk(OP_SUB,   7'd73, 7'd71, 7'd72);
            7'd57: u = mk(OP_SUB,   7'd74, 7'd9,  7'd0);
            7'd58: u = mk(OP_MUL,   7'd75, 7'd68, 7'd74);
            7'd59: u = mk(OP_ADD,   7'd76, 7'd73, 7'd75);
            7'd60: u = mk(OP_MUL,   7'd77, 7'd76, 7'd70);
            7'd61: u = mk(OP_MUL,   7'd78, 7'd67, 7'd6);
            7'd62: u = mk(OP_MUL,   7'd79, 7'd64, 7'd15);
            7'd63: u = mk(OP_SUB,   7'd80, 7'd78, 7'd79);
            7'd64: u = mk(OP_SUB,   7'd81, 7'd10, 7'd1);
            7'd65: u = mk(OP_MUL,   7'd82, 7'd68, 7'd81);
            7'd66: u = mk(OP_ADD,   7'd83, 7'd80, 7'd82);
            7'd67: u = mk(OP_MUL,   7'd84, 7'd83, 7'd70);
            7'd68: u = mk(OP_MUL,   7'd85, 7'd67, 7'd7);
            7'd69: u = mk(OP_MUL,   7'd86, 7'd64, 7'd16);
            7'd70: u = mk(OP_SUB,   7'd87, 7'd85, 7'd86);
            7'd71: u = mk(OP_SUB,   7'd88, 7'd11, 7'd2);
            7'd72: u = mk(OP_MUL,   7'd89, 7'd68, 7'd88);
            7'd73: u = mk(OP_ADD,   7'd90, 7'd87, 7'd89);
            7'd74: u = mk(OP_MUL,   7'd91, 7'd90, 7'd70);
            7'd75: u = mk(OP_MUL,   7'd92, 7'd67, 7'd8);
            7'd76: u = mk(OP_MUL,   7'd93, 7'd64, 7'd17);
            7'd77: u = mk(OP_SUB,   7'd94, 7'd92, 7'd93);
            7'd78: u = mk(OP_SUB,   7'd95, 7'd12, 7'd3);
            7'd79: u = mk(OP_MUL,   7'd96, 7'd68, 7'd95);
            7'd80: u = mk(OP_ADD,   7'd97, 7'd94, 7'd96);
            7'd81: u = mk(OP_MUL,   7'd98, 7'd97, 7'd70);
            7'd82: u = mk(OP_OUTW,  7'd0,  7'd77, 7'd0);
            7'd83: u = mk(OP_OUTW,  7'd1,  7'd84, 7'd0);
            7'd84: u = mk(OP_OUTW,  7'd2,  7'd91, 7'd0);
            7'd85: u = mk(OP_OUTW,  7'd3,  7'd98, 7'd0);
            default: u = mk(OP_FIN, 7'd0,  7'd0,  7'd0);
        endcase
        return u;
    endfunction

    // Magnitude of a signed word; the most negative value maps to 2^31
    function automatic logic [WORD_W-1:0] mag(input t_word v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Apply sign to a magnitude and saturate to the word range
    function automatic t_word sat_mag(input logic neg, input logic [47:0] m);
        logic big;
        big = |m[47:WORD_W-1];
        if (!neg) begin
            return big ? WORD_MAX : t_word'(m[WORD_W-1:0]);
        end
        return big ? WORD_MIN : t_word'(~m[WORD_W-1:0] + 1'b1);
    endfunction

    // Saturating add or subtract
    function automatic t_word sat_addsub(input t_word a, input t_word b, input logic sub);
        logic signed [WORD_W:0] s;
        s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        return t_word'(s[WORD_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// File: design/hrf_queue.sv
`default_nettype none

module hrf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hrf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output hrf_pkg::t_job o_head
);

    hrf_pkg::t_job r_slot [2];
    logic          r_wp, n_wp;
    logic          r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_slot[r_rp];

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: design/hrf_front.sv
`default_nettype none

module hrf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_side,
    input  logic                 i_axis,
    input  hrf_pkg::t_word [8:0] i_words,
    input  logic                 i_q_full,
    output logic                 o_push,
    output hrf_pkg::t_job        o_job
);

    hrf_pkg::t_word [8:0] r_left;
    logic                 r_lp, n_lp;
    logic                 acc;

    assign o_in_stall = i_q_full;
    assign acc        = i_in_valid && !i_q_full;
    assign o_push     = acc && i_side;

    // Build the job from the stored left state and the arriving right state
    always_comb begin
        o_job.present = r_lp;
        o_job.axis    = i_axis;
        o_job.lw      = r_left;
        o_job.rw      = i_words;
    end

    // Set on a left item, drop on a right item
    always_comb begin
        n_lp = r_lp;
        if (acc) begin
            n_lp = !i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= 1'b0;
        end else begin
            r_lp <= n_lp;
        end
    end

    // Hold the left state
    always_ff @(posedge i_clk) begin
        if (acc && !i_side) begin
            r_left <= i_words;
        end
    end

endmodule

`default_nettype wire

// File: design/hrf_back.sv
`default_nettype none

module hrf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hrf_pkg::GAMMA_W-1:0]   i_gamma,
    input  logic                          i_job_valid,
    input  hrf_pkg::t_job                 i_job,
    output logic                          o_job_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output hrf_pkg::t_word [3:0]          o_res,
    output logic [1:0]                    o_region,
    output logic                          o_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_MULW  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_SQRT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [4:0] LD_LAST = 5'd22;

    hrf_pkg::t_word r_mem [2**hrf_pkg::MEM_AW];
    hrf_pkg::t_word r_rda, r_rdb;

    logic [2:0]                 r_state, n_state;
    logic [hrf_pkg::PC_W-1:0]   r_pc, n_pc;
    logic [4:0]                 r_ld, n_ld;
    logic [63:0]                r_prod, n_prod;
    logic                       r_neg, n_neg;
    logic [31:0]                r_rem, n_rem;
    logic [47:0]                r_num, n_num;
    logic [47:0]                r_q, n_q;
    logic [23:0]                r_root, n_root;
    logic [25:0]                r_srem, n_srem;
    logic [5:0]                 r_cnt, n_cnt;
    logic                       r_flag, n_flag;
    logic [1:0]                 r_region, n_region;
    logic                       r_status, n_status;
    hrf_pkg::t_word [3:0]       r_res, n_res;
    logic                       r_ovalid, n_ovalid;
    hrf_pkg::t_word [3:0]       r_oword, n_oword;
    logic [1:0]                 r_oreg, n_oreg;
    logic                       r_ostat, n_ostat;

    logic                          mem_we;
    logic [hrf_pkg::MEM_AW-1:0]    mem_wa;
    hrf_pkg::t_word                mem_wd;
    hrf_pkg::t_uop                 uop_cur;
    logic [31:0]                   ma, mb;
    logic [32:0]                   div_sh;
    logic                          div_ge;
    logic [31:0]                   div_rem;
    logic [47:0]                   div_qn;
    logic [27:0]                   sq_sh, sq_tr;
    logic                          sq_ge;
    logic [25:0]                   sq_rem;
    logic [23:0]                   sq_root;
    logic [4:0]                    ld_r;
    hrf_pkg::t_word                ld_word;
    logic                          job_bad;

    assign uop_cur = hrf_pkg::uop_rom(r_pc);
    assign ma      = hrf_pkg::mag(r_rda);
    assign mb      = hrf_pkg::mag(r_rdb);

    // One restoring divide step: one quotient bit
    assign div_sh  = {r_rem, r_num[47]};
    assign div_ge  = (div_sh >= {1'b0, mb});
    assign div_rem = div_ge ? 32'(div_sh - {1'b0, mb}) : div_sh[31:0];
    assign div_qn  = {r_q[46:0], div_ge};

    // One square root step: two radicand bits, one root bit
    assign sq_sh   = {r_srem, r_num[47:46]};
    assign sq_tr   = {2'b00, r_root, 2'b01};
    assign sq_ge   = (sq_sh >= sq_tr);
    assign sq_rem  = sq_ge ? 26'(sq_sh - sq_tr) : sq_sh[25:0];
    assign sq_root = {r_root[22:0], sq_ge};

    // Reject jobs without a left state or with non-positive density or pressure
    assign job_bad = !i_job.present || (i_job.lw[0] <= 0) || (i_job.lw[4] <= 0) ||
                     (i_job.rw[0] <= 0) || (i_job.rw[4] <= 0);

    // Select the word to load into scratch
    assign ld_r = r_ld - 5'd9;
    always_comb begin
        priority if (r_ld < 5'd9) begin
            ld_word = i_job.lw[r_ld[3:0]];
        end else if (r_ld < 5'd18) begin
            ld_word = i_job.rw[ld_r[3:0]];
        end else if (r_ld == 5'd18) begin
            ld_word = hrf_pkg::t_word'({{(hrf_pkg::WORD_W-hrf_pkg::GAMMA_W){1'b0}}, i_gamma});
        end else if (r_ld == 5'd19) begin
            ld_word = hrf_pkg::HALF;
        end else if (r_ld == 5'd20) begin
            ld_word = hrf_pkg::ONE;
        end else if (r_ld == 5'd21) begin
            ld_word = i_job.axis ? i_job.lw[2] : i_job.lw[1];
        end else begin
            ld_word = i_job.axis ? i_job.rw[2] : i_job.rw[1];
        end
    end

    assign o_job_pop = ((r_state == S_LOAD) && (r_ld == LD_LAST)) ||
                       ((r_state == S_IDLE) && i_job_valid && job_bad);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_ld     = r_ld;
        n_prod   = r_prod;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_num    = r_num;
        n_q      = r_q;
        n_root   = r_root;
        n_srem   = r_srem;
        n_cnt    = r_cnt;
        n_flag   = r_flag;
        n_region = r_region;
        n_status = r_status;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_oword  = r_oword;
        n_oreg   = r_oreg;
        n_ostat  = r_ostat;
        mem_we   = 1'b0;
        mem_wa   = uop_cur.dst;
        mem_wd   = '0;

        // Drop the output item once taken
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_res    = '0;
                    n_region = hrf_pkg::REGION_LEFT;
                    n_status = 1'b1;
                    if (job_bad) begin
                        n_state = S_OUT;
                    end else begin
                        n_ld    = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                mem_we = 1'b1;
                mem_wa = hrf_pkg::MEM_AW'(r_ld);
                mem_wd = ld_word;
                n_ld   = r_ld + 1'b1;
                if (r_ld == LD_LAST) begin
                    n_pc    = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_pc    = r_pc + 1'b1;
                n_state = S_FETCH;
                unique case (uop_cur.op)
                    hrf_pkg::OP_ADD, hrf_pkg::OP_SUB: begin
                        mem_we = 1'b1;
                        mem_wd = hrf_pkg::sat_addsub(r_rda, r_rdb,
                                                     uop_cur.op == hrf_pkg::OP_SUB);
                    end
                    hrf_pkg::OP_MIN: begin
                        mem_we = 1'b1;
                        mem_wd = (r_rda < r_rdb) ? r_rda : r_rdb;
                    end
                    hrf_pkg::OP_MAX: begin
                        mem_we = 1'b1;
                        mem_wd = (r_rda > r_rdb) ? r_rda : r_rdb;
                    end
                    hrf_pkg::OP_MUL: begin
                        n_prod  = {32'd0, ma} * {32'd0, mb};
                        n_neg   = r_rda[31] ^ r_rdb[31];
                        n_pc    = r_pc;
                        n_state = S_MULW;
                    end
                    hrf_pkg::OP_DIV: begin
                        if (r_rdb == 0) begin
                            mem_we = 1'b1;
                            if (r_rda == 0) begin
                                mem_wd = '0;
                            end else begin
                                mem_wd = r_rda[31] ? hrf_pkg::WORD_MIN : hrf_pkg::WORD_MAX;
                            end
                        end else begin
                            n_rem   = '0;
                            n_num   = {ma, {hrf_pkg::FRAC_W{1'b0}}};
                            n_q     = '0;
                            n_cnt   = 6'd47;
                            n_neg   = r_rda[31] ^ r_rdb[31];
                            n_pc    = r_pc;
                            n_state = S_DIV;
                        end
                    end
                    hrf_pkg::OP_SQRT, hrf_pkg::OP_SQRTF: begin
                        if (r_rda <= 0 || (uop_cur.op == hrf_pkg::OP_SQRTF && !r_flag)) begin
                            mem_we = 1'b1;
                            mem_wd = '0;
                        end else begin
                            n_srem  = '0;
                            n_root  = '0;
                            n_num   = {r_rda, {hrf_pkg::FRAC_W{1'b0}}};
                            n_cnt   = 6'd23;
                            n_pc    = r_pc;
                            n_state = S_SQRT;
                        end
                    end
                    hrf_pkg::OP_POS2: begin
                        n_flag = (r_rda > 0) && (r_rdb > 0);
                    end
                    hrf_pkg::OP_DECIDE: begin
                        // r_rda is SL, r_rdb is SR
                        priority if (r_rda == r_rdb) begin
                            n_pc = hrf_pkg::PC_FIN;
                        end else if (r_rda >= 0) begin
                            n_status = 1'b0;
                            n_region = hrf_pkg::REGION_LEFT;
                            n_pc     = hrf_pkg::PC_SEL;
                        end else if (r_rdb <= 0) begin
                            n_status = 1'b0;
                            n_region = hrf_pkg::REGION_RIGHT;
                            n_pc     = hrf_pkg::PC_SEL;
                        end else begin
                            n_status = 1'b0;
                            n_region = hrf_pkg::REGION_BLEND;
                            n_pc     = hrf_pkg::PC_BLEND;
                        end
                    end
                    hrf_pkg::OP_OUTS: begin
                        n_res[uop_cur.dst[1:0]] =
                            (r_region == hrf_pkg::REGION_RIGHT) ? r_rdb : r_rda;
                    end
                    hrf_pkg::OP_OUTW: begin
                        n_res[uop_cur.dst[1:0]] = r_rda;
                    end
                    default: begin
                        n_pc    = r_pc;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_MULW: begin
                mem_we  = 1'b1;
                mem_wd  = hrf_pkg::sat_mag(r_neg, r_prod[63:hrf_pkg::FRAC_W]);
                n_pc    = r_pc + 1'b1;
                n_state = S_FETCH;
            end
            S_DIV: begin
                n_rem = div_rem;
                n_num = {r_num[46:0], 1'b0};
                n_q   = div_qn;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 6'd0) begin
                    mem_we  = 1'b1;
                    mem_wd  = hrf_pkg::sat_mag(r_neg, div_qn);
                    n_pc    = r_pc + 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_SQRT: begin
                n_srem = sq_rem;
                n_root = sq_root;
                n_num  = {r_num[45:0], 2'b00};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == 6'd0) begin
                    mem_we  = 1'b1;
                    mem_wd  = hrf_pkg::t_word'({8'd0, sq_root});
                    n_pc    = r_pc + 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_res;
                    n_oreg   = r_region;
                    n_ostat  = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_ld     <= '0;
            r_cnt    <= '0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_ld     <= n_ld;
            r_cnt    <= n_cnt;
            r_flag   <= n_flag;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_num    <= n_num;
        r_q      <= n_q;
        r_root   <= n_root;
        r_srem   <= n_srem;
        r_region <= n_region;
        r_status <= n_status;
        r_res    <= n_res;
        r_oword  <= n_oword;
        r_oreg   <= n_oreg;
        r_ostat  <= n_ostat;
    end

    // Scratch memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rda <= r_mem[uop_cur.src_a];
        r_rdb <= r_mem[uop_cur.src_b];
    end

    assign o_out_valid = r_ovalid;
    assign o_res       = r_oword;
    assign o_region    = r_oreg;
    assign o_status    = r_ostat;

endmodule

`default_nettype wire

// File: design/hll_riemann_flux_top.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_side, i_axis, i_density .. i_flux_energy
// output    o_out_valid / i_out_stall  o_out_mass .. o_out_energy, o_region, o_status
// config    i_cfg_we                   i_cfg_data (gamma ratio, unsigned Q2.16)
//
// A left item is stored by the front end while the queue is not full. A right item
// runs on one shared sequencer, whose run time is set by the restoring divider (one
// quotient bit per cycle) and the square root unit; a blended result runs more steps.
// An invalid job skips the sequencer and goes straight to the output stage.
// A two-entry job queue lets the input side keep taking items while the sequencer
// works; the output register holds a result while the far side stalls.
// Reset is synchronous, active low; gamma returns to 1.4. No clearing pass.
`default_nettype none

`include "hll_riemann_flux_top_assert.svh"

module hll_riemann_flux_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hrf_pkg::GAMMA_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_side,
    input  logic                          i_axis,
    input  logic signed [31:0]            i_density,
    input  logic signed [31:0]            i_momentum_x,
    input  logic signed [31:0]            i_momentum_y,
    input  logic signed [31:0]            i_total_energy,
    input  logic signed [31:0]            i_pressure,
    input  logic signed [31:0]            i_flux_mass,
    input  logic signed [31:0]            i_flux_mom_x,
    input  logic signed [31:0]            i_flux_mom_y,
    input  logic signed [31:0]            i_flux_energy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_out_mass,
    output logic signed [31:0]            o_out_mom_x,
    output logic signed [31:0]            o_out_mom_y,
    output logic signed [31:0]            o_out_energy,
    output logic [1:0]                    o_region,
    output logic                          o_status
);

    logic [hrf_pkg::GAMMA_W-1:0] r_gamma;
    hrf_pkg::t_word [8:0]        in_words;
    hrf_pkg::t_job               push_job, head_job;
    hrf_pkg::t_word [3:0]        res;
    logic                        q_push, q_pop, q_full, q_valid;
    logic                        out_zero;
    logic                        in_acc;

    // Gamma register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= hrf_pkg::GAMMA_RST;
        end else if (i_cfg_we) begin
            r_gamma <= i_cfg_data;
        end
    end

    assign in_words = {i_flux_energy, i_flux_mom_y, i_flux_mom_x, i_flux_mass, i_pressure,
                       i_total_energy, i_momentum_y, i_momentum_x, i_density};

    hrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_side     (i_side),
        .i_axis     (i_axis),
        .i_words    (in_words),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    hrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    hrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gamma     (r_gamma),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_job_pop   (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (res),
        .o_region    (o_region),
        .o_status    (o_status)
    );

    assign o_out_mass   = res[0];
    assign o_out_mom_x  = res[1];
    assign o_out_mom_y  = res[2];
    assign o_out_energy = res[3];

    // Terms for the checks below
    assign out_zero = (o_out_mass == 0) && (o_out_mom_x == 0) && (o_out_mom_y == 0) &&
                      (o_out_energy == 0) && (o_region == hrf_pkg::REGION_LEFT);
    assign in_acc   = i_in_valid && !o_in_stall;

    `HRF_ASSERT_IMP(a_invalid_zero, o_out_valid && o_status, out_zero, "invalid flux nonzero")
    `HRF_ASSERT_IMP(a_push_right, q_push, in_acc && i_side, "push without right item")
    `HRF_ASSERT_NXT(a_cfg_write, i_cfg_we, r_gamma == $past(i_cfg_data), "gamma write lost")

endmodule

`default_nettype wire
